// File: design/dns_a_record_extractor_top_macros.svh
// Assertion macros used by the checker of the DNS A-record extractor.
`ifndef DNS_A_RECORD_EXTRACTOR_TOP_MACROS_SVH
`define DNS_A_RECORD_EXTRACTOR_TOP_MACROS_SVH

// Next-cycle implication, ignored while reset is asserted.
`define DARE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dare assertion failed");

// Next-cycle implication that also holds across reset.
`define DARE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dare assertion failed");

`endif

// File: design/dare_pkg.sv
// Types and constants of the DNS A-record extractor.
package dare_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_PREFIX = 4'd0,
        PH_HEADER = 4'd1,
        PH_QLEN   = 4'd2,
        PH_QLABEL = 4'd3,
        PH_QTAIL  = 4'd4,
        PH_ALEN   = 4'd5,
        PH_ALABEL = 4'd6,
        PH_APTR   = 4'd7,
        PH_AFIX   = 4'd8,
        PH_RDATA  = 4'd9,
        PH_DONE   = 4'd10
    } t_dare_phase;

    // Classified byte as held in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       is_ptr;
    } t_dare_entry;

    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [15:0] TYPE_A       = 16'h0001;
    localparam logic [3:0]  PREFIX_LEN   = 4'd2;
    localparam logic [3:0]  HEADER_LEN   = 4'd12;
    localparam logic [3:0]  ANCOUNT_HI   = 4'd6;
    localparam logic [3:0]  ANCOUNT_LO   = 4'd7;
    localparam logic [3:0]  QTAIL_LEN    = 4'd4;
    localparam logic [3:0]  AFIX_TYPE_HI = 4'd0;
    localparam logic [3:0]  AFIX_TYPE_LO = 4'd1;
    localparam logic [3:0]  AFIX_LEN_HI  = 4'd8;
    localparam logic [3:0]  AFIX_LEN_LO  = 4'd9;
    localparam logic [3:0]  AFIX_LEN     = 4'd10;
    localparam logic [3:0]  ADDR_LEN     = 4'd4;

endpackage

// File: design/dare_front.sv
// Front end: takes message bytes and classifies them for the parser.
module dare_front
    import dare_pkg::*;
(
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_push,
    output t_dare_entry o_entry,
    input  logic        i_q_full
);

    // Request accepted whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Byte classification used by the name walkers
    always_comb begin
        o_entry.data    = i_in_byte;
        o_entry.last    = i_in_last;
        o_entry.is_zero = (i_in_byte == 8'h00);
        o_entry.is_ptr  = ((i_in_byte & PTR_MASK) == PTR_MASK);
    end

endmodule

// File: design/dare_queue.sv
// Short FIFO between the classifier and the parser.
module dare_queue
    import dare_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_dare_entry i_entry,
    output logic        o_full,
    output logic        o_valid,
    input  logic        i_pop,
    output t_dare_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_dare_entry     r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/dare_back.sv
// Back end: DNS message parser and result register.
module dare_back
    import dare_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tcp_framing,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_dare_entry i_q_entry,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_ipv4_address,
    output logic [15:0] o_answer_index
);

    t_dare_phase r_phase, n_phase;
    logic [15:0] r_field_left, n_field_left;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_ans_total, n_ans_total;
    logic [15:0] r_ans_done, n_ans_done;
    logic [15:0] r_cur_type, n_cur_type;
    logic [31:0] r_addr, n_addr;
    logic        r_q_nonempty, n_q_nonempty;
    logic        n_emit;

    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [15:0] r_out_idx;

    logic        w_pop;
    logic [7:0]  w_b;
    logic [15:0] w_done_inc;
    logic [31:0] w_emit_addr;

    assign w_b         = i_q_entry.data;
    assign w_done_inc  = r_ans_done + 16'd1;
    // Address including the current byte, taken before the answer wraps up
    assign w_emit_addr = {r_addr[23:0], w_b};

    // Take a byte when the result slot is free or being drained
    always_comb begin
        w_pop   = i_q_valid && (!r_out_valid || i_out_ready);
        o_q_pop = w_pop;
    end

    // Parser next state
    always_comb begin
        n_phase      = r_phase;
        n_field_left = r_field_left;
        n_pos        = r_pos;
        n_ans_total  = r_ans_total;
        n_ans_done   = r_ans_done;
        n_cur_type   = r_cur_type;
        n_addr       = r_addr;
        n_q_nonempty = r_q_nonempty;
        n_emit       = 1'b0;

        unique case (r_phase)
            PH_PREFIX: begin
                n_pos = r_pos + 4'd1;
                if (n_pos >= PREFIX_LEN) begin
                    n_pos   = '0;
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (r_pos == ANCOUNT_HI) begin
                    n_ans_total = {w_b, r_ans_total[7:0]};
                end else if (r_pos == ANCOUNT_LO) begin
                    n_ans_total = {r_ans_total[15:8], w_b};
                end
                n_pos = r_pos + 4'd1;
                if (n_pos >= HEADER_LEN) begin
                    n_pos   = '0;
                    n_phase = PH_QLEN;
                end
            end
            PH_QLEN: begin
                if (i_q_entry.is_zero) begin
                    n_pos   = '0;
                    n_phase = r_q_nonempty ? PH_QTAIL : PH_DONE;
                end else begin
                    n_q_nonempty = 1'b1;
                    n_field_left = {8'h00, w_b};
                    n_phase      = PH_QLABEL;
                end
            end
            PH_QLABEL: begin
                n_field_left = r_field_left - 16'd1;
                if (n_field_left == '0) begin
                    n_phase = PH_QLEN;
                end
            end
            PH_QTAIL: begin
                n_pos = r_pos + 4'd1;
                if (n_pos >= QTAIL_LEN) begin
                    n_pos   = '0;
                    n_phase = (r_ans_total == '0) ? PH_DONE : PH_ALEN;
                end
            end
            PH_ALEN: begin
                priority if (i_q_entry.is_ptr) begin
                    n_phase = PH_APTR;
                end else if (i_q_entry.is_zero) begin
                    n_pos   = '0;
                    n_phase = PH_AFIX;
                end else begin
                    n_field_left = {8'h00, w_b};
                    n_phase      = PH_ALABEL;
                end
            end
            PH_ALABEL: begin
                n_field_left = r_field_left - 16'd1;
                if (n_field_left == '0) begin
                    n_phase = PH_ALEN;
                end
            end
            PH_APTR: begin
                n_pos   = '0;
                n_phase = PH_AFIX;
            end
            PH_AFIX: begin
                if (r_pos == AFIX_TYPE_HI) begin
                    n_cur_type = {w_b, 8'h00};
                end else if (r_pos == AFIX_TYPE_LO) begin
                    n_cur_type = {r_cur_type[15:8], w_b};
                end else if (r_pos == AFIX_LEN_HI) begin
                    n_field_left = {w_b, 8'h00};
                end else if (r_pos == AFIX_LEN_LO) begin
                    n_field_left = {r_field_left[15:8], w_b};
                end
                n_pos = r_pos + 4'd1;
                if (n_pos >= AFIX_LEN) begin
                    n_pos  = '0;
                    n_addr = '0;
                    if (n_field_left == '0) begin
                        // empty record data ends the answer at once
                        n_ans_done = w_done_inc;
                        n_phase    = (w_done_inc == r_ans_total) ? PH_DONE : PH_ALEN;
                    end else begin
                        n_phase = PH_RDATA;
                    end
                end
            end
            PH_RDATA: begin
                if (r_cur_type == TYPE_A && r_pos < ADDR_LEN) begin
                    n_addr = w_emit_addr;
                    n_pos  = r_pos + 4'd1;
                    n_emit = (n_pos == ADDR_LEN);
                end
                n_field_left = r_field_left - 16'd1;
                if (n_field_left == '0) begin
                    n_ans_done = w_done_inc;
                    n_pos      = '0;
                    n_addr     = '0;
                    n_phase    = (w_done_inc == r_ans_total) ? PH_DONE : PH_ALEN;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // Final byte restarts the parser for the next message
        if (i_q_entry.last) begin
            n_phase      = i_tcp_framing ? PH_PREFIX : PH_HEADER;
            n_field_left = '0;
            n_pos        = '0;
            n_ans_total  = '0;
            n_ans_done   = '0;
            n_cur_type   = '0;
            n_addr       = '0;
            n_q_nonempty = 1'b0;
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_field_left <= '0;
            r_pos        <= '0;
            r_ans_total  <= '0;
            r_ans_done   <= '0;
            r_cur_type   <= '0;
            r_addr       <= '0;
            r_q_nonempty <= 1'b0;
        end else if (w_pop) begin
            r_phase      <= n_phase;
            r_field_left <= n_field_left;
            r_pos        <= n_pos;
            r_ans_total  <= n_ans_total;
            r_ans_done   <= n_ans_done;
            r_cur_type   <= n_cur_type;
            r_addr       <= n_addr;
            r_q_nonempty <= n_q_nonempty;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && n_emit) begin
            r_out_addr <= w_emit_addr;
            r_out_idx  <= r_ans_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ipv4_address = r_out_addr;
    assign o_answer_index = r_out_idx;

endmodule

// File: design/dns_a_record_extractor_top.sv
// A byte that completes an A record passes through the queue, then the result register.
// Throughput: one byte per cycle unless output stalls; the parser steps once per byte.
// The two-entry queue and the result register let input and output stall on their own.
// Reset (synchronous, active low) empties the queue and result slot, clears
// tcp_framing and starts the parser in the header phase.
module dns_a_record_extractor_top
    import dare_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_ipv4_address,
    output logic [15:0] o_answer_index
);

    logic        r_tcp_framing;
    logic        w_push, w_full, w_q_valid, w_q_pop;
    t_dare_entry w_push_entry, w_q_entry;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp_framing <= 1'b0;
        end else if (i_cfg_we) begin
            r_tcp_framing <= i_cfg_data;
        end
    end

    dare_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_push     (w_push),
        .o_entry    (w_push_entry),
        .i_q_full   (w_full)
    );

    dare_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_entry (w_q_entry)
    );

    dare_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tcp_framing  (r_tcp_framing),
        .i_q_valid      (w_q_valid),
        .o_q_pop        (w_q_pop),
        .i_q_entry      (w_q_entry),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ipv4_address (o_ipv4_address),
        .o_answer_index (o_answer_index)
    );

endmodule

// File: design/dare_checker.sv
// Port-level checker for the DNS A-record extractor, bound to the top level.
`include "dns_a_record_extractor_top_macros.svh"

module dare_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_ipv4_address,
    input logic [15:0] o_answer_index
);

    // A stalled result stays offered
    `DARE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its address
    `DARE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_ipv4_address) && $stable(o_answer_index))

    // Reset leaves the queue empty and ready for a request
    `DARE_ASSERT_NEXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, o_in_ready)

    // Reset drops any pending result
    `DARE_ASSERT_NEXT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n, !o_out_valid)

    // Idle input and a drained result slot keep the output quiet
    `DARE_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !i_in_valid && o_in_ready && !o_out_valid && $past(o_in_ready) && $past(!i_in_valid), !o_out_valid)

endmodule

bind dns_a_record_extractor_top dare_checker u_dare_checker (.*);

// File: tb/tb_dns_a_record_extractor_top.sv
// Testbench for the DNS A-record extractor: byte stream stimulus, in-bench parser model, scoreboard.
module tb_dns_a_record_extractor_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dare_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned PHASE_BYTES    = 250;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } wire_byte_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] idx;
    } a_record_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_data  = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_in_last   = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_ipv4_address;
    logic [15:0] o_answer_index;

    dns_a_record_extractor_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ipv4_address (o_ipv4_address),
        .o_answer_index (o_answer_index)
    );

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    wire_byte_t  wire_bytes[$];
    a_record_t   pending_a_records[$];
    logic [7:0]  msg_bytes[$];
    int unsigned phase_bytes;
    int unsigned mismatches     = 0;
    int unsigned stalled_cycles = 0;
    int unsigned tx_idle_pct    = 9;
    int unsigned rx_idle_pct    = 75;
    int unsigned hold_left      = 0;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    logic        framing_cfg    = 1'b0;  // register value as last written
    logic        wire_framing   = 1'b0;  // framing the next message is parsed with

    // Parser state of the in-bench model
    t_dare_phase prs_phase;
    logic [15:0] bytes_left;
    logic [3:0]  hdr_pos;
    logic [15:0] an_total;
    logic [15:0] ans_done;
    logic [15:0] rr_type;
    logic [31:0] addr_acc;
    logic        q_nonempty;

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    task automatic restart_parse();
        prs_phase  = framing_cfg ? PH_PREFIX : PH_HEADER;
        bytes_left = '0;
        hdr_pos    = '0;
        an_total   = '0;
        ans_done   = '0;
        rr_type    = '0;
        addr_acc   = '0;
        q_nonempty = 1'b0;
    endtask

    task automatic close_answer();
        ans_done++;
        hdr_pos   = '0;
        addr_acc  = '0;
        prs_phase = (ans_done == an_total) ? PH_DONE : PH_ALEN;
    endtask

    // One byte through the parser model; hit flags a completed A record
    task automatic parse_dns_byte(input logic [7:0] b, input logic is_last,
                                  output logic hit, output a_record_t rec);
        hit = 1'b0;
        rec = '0;
        case (prs_phase)
            PH_PREFIX: begin
                hdr_pos++;
                if (hdr_pos >= PREFIX_LEN) begin
                    hdr_pos   = '0;
                    prs_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (hdr_pos == ANCOUNT_HI) an_total[15:8] = b;
                else if (hdr_pos == ANCOUNT_LO) an_total[7:0] = b;
                hdr_pos++;
                if (hdr_pos >= HEADER_LEN) begin
                    hdr_pos   = '0;
                    prs_phase = PH_QLEN;
                end
            end
            PH_QLEN: begin
                if (b == 8'h00) begin
                    hdr_pos   = '0;
                    prs_phase = q_nonempty ? PH_QTAIL : PH_DONE;
                end else begin
                    q_nonempty = 1'b1;
                    bytes_left = {8'h00, b};
                    prs_phase  = PH_QLABEL;
                end
            end
            PH_QLABEL: begin
                bytes_left--;
                if (bytes_left == 16'h0000) prs_phase = PH_QLEN;
            end
            PH_QTAIL: begin
                hdr_pos++;
                if (hdr_pos >= QTAIL_LEN) begin
                    hdr_pos   = '0;
                    prs_phase = (an_total == 16'h0000) ? PH_DONE : PH_ALEN;
                end
            end
            PH_ALEN: begin
                if ((b & PTR_MASK) == PTR_MASK) begin
                    prs_phase = PH_APTR;
                end else if (b == 8'h00) begin
                    hdr_pos   = '0;
                    prs_phase = PH_AFIX;
                end else begin
                    bytes_left = {8'h00, b};
                    prs_phase  = PH_ALABEL;
                end
            end
            PH_ALABEL: begin
                bytes_left--;
                if (bytes_left == 16'h0000) prs_phase = PH_ALEN;
            end
            PH_APTR: begin
                hdr_pos   = '0;
                prs_phase = PH_AFIX;
            end
            PH_AFIX: begin
                if (hdr_pos == AFIX_TYPE_HI) rr_type = {b, 8'h00};
                else if (hdr_pos == AFIX_TYPE_LO) rr_type[7:0] = b;
                else if (hdr_pos == AFIX_LEN_HI) bytes_left = {b, 8'h00};
                else if (hdr_pos == AFIX_LEN_LO) bytes_left[7:0] = b;
                hdr_pos++;
                if (hdr_pos >= AFIX_LEN) begin
                    hdr_pos  = '0;
                    addr_acc = '0;
                    if (bytes_left == 16'h0000) close_answer();
                    else prs_phase = PH_RDATA;
                end
            end
            PH_RDATA: begin
                if (rr_type == TYPE_A && hdr_pos < ADDR_LEN) begin
                    addr_acc = {addr_acc[23:0], b};
                    hdr_pos++;
                    if (hdr_pos == ADDR_LEN) begin
                        hit      = 1'b1;
                        rec.addr = addr_acc;
                        rec.idx  = ans_done;
                    end
                end
                bytes_left--;
                if (bytes_left == 16'h0000) close_answer();
            end
            default: ;
        endcase
        if (is_last) restart_parse();
    endtask

    // Queue the message in msg_bytes, flagging its final byte
    task automatic send_message();
        foreach (msg_bytes[i])
            wire_bytes.push_back('{data: msg_bytes[i], is_last: (i == msg_bytes.size() - 1)});
        phase_bytes += msg_bytes.size();
        wire_framing = framing_cfg;
    endtask

    // Short response: one question "a" or an empty one, one answer with pointer owner and A data
    task automatic build_a_message(input logic [31:0] addr, input logic empty_question);
        msg_bytes.delete();
        if (wire_framing) msg_bytes = {8'h00, 8'h23};
        msg_bytes = {msg_bytes, 8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01,
                     8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        if (!empty_question) msg_bytes = {msg_bytes, 8'h01, 8'h61};
        msg_bytes = {msg_bytes, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                     8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h0E, 8'h10,
                     8'h00, 8'h04, addr[31:24], addr[23:16], addr[15:8], addr[7:0]};
    endtask

    // Label with random content; rare long lengths with a top bit set
    task automatic put_label(input logic in_answer);
        int unsigned len;
        if ($urandom_range(99) < 4)
            len = in_answer ? $urandom_range(8'h40, 8'hBF) : $urandom_range(1, 255);
        else
            len = $urandom_range(1, 8);
        msg_bytes.push_back(8'(len));
        repeat (len) msg_bytes.push_back(8'($urandom));
    endtask

    // Mostly well-formed responses with random content, some noise and truncation
    task automatic queue_random_message();
        int unsigned n_ans;
        int unsigned pick;
        int unsigned rdlen;
        int unsigned keep;
        logic [15:0] an_count;
        logic [15:0] rr;
        msg_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
        end else begin
            if (wire_framing) repeat (2) msg_bytes.push_back(8'($urandom));
            n_ans = $urandom_range(0, 4);
            pick  = $urandom_range(99);
            if (pick < 6) an_count = 16'($urandom);
            else if (pick < 14) an_count = 16'($urandom_range(0, 5));
            else an_count = 16'(n_ans);
            // header, answer count at bytes 6 and 7
            for (int i = 0; i < 12; i++) begin
                if (i == 6) msg_bytes.push_back(an_count[15:8]);
                else if (i == 7) msg_bytes.push_back(an_count[7:0]);
                else msg_bytes.push_back(8'($urandom));
            end
            // question name, then type and class
            if ($urandom_range(99) >= 8) repeat ($urandom_range(1, 3)) put_label(1'b0);
            msg_bytes.push_back(8'h00);
            repeat (4) msg_bytes.push_back(8'($urandom));
            // answers
            for (int a = 0; a < n_ans; a++) begin
                pick = $urandom_range(2);
                if (pick != 0) repeat ($urandom_range(1, 2)) put_label(1'b1);
                if (pick == 1) begin
                    msg_bytes.push_back(8'h00);
                end else begin
                    msg_bytes.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
                    msg_bytes.push_back(8'($urandom));
                end
                rr = ($urandom_range(99) < 70) ? TYPE_A : 16'($urandom);
                msg_bytes.push_back(rr[15:8]);
                msg_bytes.push_back(rr[7:0]);
                repeat (6) msg_bytes.push_back(8'($urandom));
                if (rr == TYPE_A)
                    rdlen = ($urandom_range(99) < 75) ? 4 : $urandom_range(0, 8);
                else
                    rdlen = $urandom_range(0, 12);
                msg_bytes.push_back(8'(rdlen >> 8));
                msg_bytes.push_back(8'(rdlen));
                repeat (rdlen) msg_bytes.push_back(8'($urandom));
            end
            // trailing sections
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
            // early end
            if ($urandom_range(99) < 10) begin
                keep = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
            end
        end
        send_message();
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (wire_bytes.size() != 0 || i_in_valid || pending_a_records.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write while idle, then a one-byte message so the new framing takes hold
    task automatic write_framing(input logic v);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        framing_cfg = v;
        @(negedge i_clk);
        msg_bytes = {8'($urandom)};
        send_message();
    endtask

    // Request driver
    always @(posedge i_clk) begin : driver
        wire_byte_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (wire_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = wire_bytes.pop_front();
                i_in_valid <= 1'b1;
                i_in_byte  <= nxt.data;
                i_in_last  <= nxt.is_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: check results first, then predict from the accepted byte
    always @(posedge i_clk) begin : monitor
        a_record_t exp_rec;
        a_record_t new_rec;
        logic      hit;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_a_records.size() == 0) begin
                    flag_mismatch($sformatf("unexpected record: addr %h index %0d",
                                            o_ipv4_address, o_answer_index));
                end else begin
                    exp_rec = pending_a_records.pop_front();
                    if (o_ipv4_address !== exp_rec.addr || o_answer_index !== exp_rec.idx)
                        flag_mismatch($sformatf(
                            "record mismatch: expected addr %h index %0d, got addr %h index %0d",
                            exp_rec.addr, exp_rec.idx, o_ipv4_address, o_answer_index));
                end
            end
            if (i_in_valid && o_in_ready) begin
                parse_dns_byte(i_in_byte, i_in_last, hit, new_rec);
                if (hit) pending_a_records.push_back(new_rec);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence
    initial begin
        restart_parse();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A record ending on the final byte of the message
        build_a_message(32'hFF00_A55A, 1'b0);
        send_message();
        // empty question name: no records
        build_a_message(32'h0102_0304, 1'b1);
        send_message();
        // zero answers, trailing bytes ignored
        msg_bytes = {8'h55, 8'hAA, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h01, 8'h61, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                     8'hC0, 8'h0C, 8'h00, 8'h01};
        send_message();
        // four answers: short A, A behind a long label, CNAME, A behind label plus pointer
        msg_bytes = {8'hAB, 8'hCD, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h04, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h01, 8'h62, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                     8'h01, 8'h62, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                     8'h10, 8'h00, 8'h03, 8'h0A, 8'h0B, 8'h0C, 8'h41};
        repeat (65) msg_bytes.push_back(8'($urandom));
        msg_bytes = {msg_bytes, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h10,
                     8'h00, 8'h06, 8'hC0, 8'hA8, 8'h01, 8'hFE, 8'h77, 8'h88,
                     8'hC0, 8'h0C, 8'h00, 8'h05, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h02, 8'h01, 8'h02,
                     8'h01, 8'h63, 8'hC0, 8'h10, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                     8'h00, 8'h01, 8'h00, 8'h04, 8'h7F, 8'h00, 8'h00, 8'h01,
                     8'h00, 8'h00, 8'h29};
        send_message();
        // message cut inside the address, then a clean one
        build_a_message(32'h0A0B_0C0D, 1'b0);
        void'(msg_bytes.pop_back());
        void'(msg_bytes.pop_back());
        send_message();
        build_a_message(32'h5AA5_00FF, 1'b0);
        send_message();
        // length prefix
        write_framing(1'b1);
        build_a_message(32'hC633_6407, 1'b0);
        send_message();

        // Random phases: framing alternates, idling shifts from receiver to sender to none
        for (int p = 0; p < 6; p++) begin
            write_framing(p % 2 == 0);
            case (p / 2)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 75; end
                1: begin tx_idle_pct = 75; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (p == 4) long_hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) queue_random_message();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: dns_a_record_extractor_top.f
+incdir+design
design/dare_pkg.sv
design/dare_front.sv
design/dare_queue.sv
design/dare_back.sv
design/dns_a_record_extractor_top.sv
design/dare_checker.sv
tb/tb_dns_a_record_extractor_top.sv
